@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl, included by prescaled_reload_timer.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/prt_pkg.sv @@
// types and codes for the prescaled reload timer
package prt_pkg;

    localparam int DATA_W = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_IRQ_EN  = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_EVENT   = 3'd3;
    localparam logic [2:0] REG_COUNTER = 3'd4;
    localparam logic [2:0] REG_PRESC   = 3'd5;
    localparam logic [2:0] REG_RELOAD  = 3'd6;

    // control register bit positions
    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_URS_BIT = 2;
    localparam int CTRL_OPM_BIT = 3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [2:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } result_t;

endpackage

@@ hw/rtl/prt_if.sv @@
// valid/ready channels for request and response transactions
interface prt_req_if;
    import prt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [2:0]        reg_index;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, cmd, reg_index, write_data, input ready);
    modport sink (input valid, cmd, reg_index, write_data, output ready);
endinterface

interface prt_rsp_if;
    import prt_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq;

    modport source (output valid, read_data, irq, input ready);
    modport sink (input valid, read_data, irq, output ready);
endinterface

@@ hw/rtl/prt_regs.sv @@
// timer state, register file and per-transaction update
module prt_regs
    import prt_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    output result_t result
);

    localparam int CW = COUNT_WIDTH;

    logic          run_en_reg, run_en_next;
    logic          urs_reg, urs_next;
    logic          opm_reg, opm_next;
    logic          irq_en_reg, irq_en_next;
    logic          flag_reg, flag_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] presc_wr_reg, presc_wr_next;
    logic [CW-1:0] presc_act_reg, presc_act_next;
    logic [CW-1:0] presc_cnt_reg, presc_cnt_next;
    logic [CW-1:0] reload_reg, reload_next;

    logic [CW-1:0]     wval;
    logic [DATA_W-1:0] rdata;

    assign wval = CW'(item.write_data);

    always_comb
    begin
        run_en_next    = run_en_reg;
        urs_next       = urs_reg;
        opm_next       = opm_reg;
        irq_en_next    = irq_en_reg;
        flag_next      = flag_reg;
        count_next     = count_reg;
        presc_wr_next  = presc_wr_reg;
        presc_act_next = presc_act_reg;
        presc_cnt_next = presc_cnt_reg;
        reload_next    = reload_reg;
        rdata          = '0;

        unique case (item.cmd)
            CMD_TICK:
            begin
                if (run_en_reg)
                begin
                    if (presc_cnt_reg != presc_act_reg)
                    begin
                        presc_cnt_next = presc_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        presc_cnt_next = '0;
                        if (count_reg == reload_reg)
                        begin
                            // update event: wrap, load the buffered prescaler, set the flag, stop in one-pulse mode
                            count_next     = '0;
                            presc_act_next = presc_wr_reg;
                            flag_next      = 1'b1;
                            if (opm_reg)
                            begin
                                run_en_next = 1'b0;
                            end
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                unique case (item.reg_index)
                    REG_CTRL:
                    begin
                        rdata[CTRL_EN_BIT]  = run_en_reg;
                        rdata[CTRL_URS_BIT] = urs_reg;
                        rdata[CTRL_OPM_BIT] = opm_reg;
                    end
                    REG_IRQ_EN:  rdata[0] = irq_en_reg;
                    REG_STATUS:  rdata[0] = flag_reg;
                    REG_COUNTER: rdata = DATA_W'(count_reg);
                    REG_PRESC:   rdata = DATA_W'(presc_wr_reg);
                    REG_RELOAD:  rdata = DATA_W'(reload_reg);
                    default:     rdata = '0;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.reg_index)
                    REG_CTRL:
                    begin
                        run_en_next = item.write_data[CTRL_EN_BIT];
                        urs_next    = item.write_data[CTRL_URS_BIT];
                        opm_next    = item.write_data[CTRL_OPM_BIT];
                    end
                    REG_IRQ_EN: irq_en_next = item.write_data[0];
                    REG_STATUS:
                    begin
                        // write zero to clear, one leaves the flag alone
                        if (!item.write_data[0])
                        begin
                            flag_next = 1'b0;
                        end
                    end
                    REG_EVENT:
                    begin
                        if (item.write_data[0])
                        begin
                            count_next     = '0;
                            presc_cnt_next = '0;
                            presc_act_next = presc_wr_reg;
                            if (!urs_reg)
                            begin
                                flag_next = 1'b1;
                            end
                        end
                    end
                    REG_COUNTER: count_next    = wval;
                    REG_PRESC:   presc_wr_next = wval;
                    REG_RELOAD:  reload_next   = wval;
                    default:     ;
                endcase
            end
            default: ;
        endcase
    end

    assign result.read_data = rdata;
    assign result.irq       = flag_next & irq_en_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_en_reg    <= 1'b0;
            urs_reg       <= 1'b0;
            opm_reg       <= 1'b0;
            irq_en_reg    <= 1'b0;
            flag_reg      <= 1'b0;
            count_reg     <= '0;
            presc_wr_reg  <= '0;
            presc_act_reg <= '0;
            presc_cnt_reg <= '0;
            reload_reg    <= '1;
        end
        else if (accept)
        begin
            run_en_reg    <= run_en_next;
            urs_reg       <= urs_next;
            opm_reg       <= opm_next;
            irq_en_reg    <= irq_en_next;
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            presc_wr_reg  <= presc_wr_next;
            presc_act_reg <= presc_act_next;
            presc_cnt_reg <= presc_cnt_next;
            reload_reg    <= reload_next;
        end
    end

endmodule

@@ hw/rtl/prescaled_reload_timer.sv @@
// responses are registered in out_reg, or in skid_reg while the output stalls
// one transaction per cycle while req.ready is high; timer state updates on accept
// a two-entry output buffer keeps req.ready high for one stalled response
// reset: rst_n clears all timer state, reload to all ones, output buffer empty
`include "assert_macros.svh"

module prescaled_reload_timer
    import prt_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    prt_req_if.sink    req,
    prt_rsp_if.source  rsp
);

    item_t   item;
    result_t result;
    logic    req_accept;
    logic    out_take;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign item.cmd        = req.cmd;
    assign item.reg_index  = req.reg_index;
    assign item.write_data = req.write_data;

    assign req.ready  = !skid_valid_reg;
    assign req_accept = req.valid && req.ready;
    assign out_take   = out_valid_reg && rsp.ready;

    prt_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (req_accept),
        .item   (item),
        .result (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = req_accept;
            end
        end
        else if (req_accept)
        begin
            // output stalled, park the new response
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_reg.read_data;
    assign rsp.irq       = out_reg.irq;

    `PRT_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `PRT_ASSERT_NXT(a_fill_empty_out, clk, rst_n, req_accept && !out_valid_reg, out_valid_reg && !skid_valid_reg)
    `PRT_ASSERT_NXT(a_park_on_stall, clk, rst_n, req_accept && out_valid_reg && !rsp.ready, skid_valid_reg && out_valid_reg)

endmodule

@@ dv/tb_prescaled_reload_timer.sv @@
// self-checking testbench for the prescaled reload timer
`timescale 1ns / 100ps

module tb_prescaled_reload_timer;
    import prt_pkg::*;

    localparam int CNT_W = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 100;
    localparam int unsigned HOLD_AT_A = 600;
    localparam int unsigned HOLD_AT_B = 2000;
    localparam int unsigned RANDOM_ITEMS = 1200;

    typedef struct {
        item_t item;
        bit    drain;
    } bus_request_t;

    logic clk;
    logic rst_n = 1'b0;

    prt_req_if req();
    prt_rsp_if rsp();

    prescaled_reload_timer #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // timer state as predicted from the accepted transactions
    logic             t_en = 1'b0;
    logic             t_urs = 1'b0;
    logic             t_opm = 1'b0;
    logic             t_irq_en = 1'b0;
    logic             t_flag = 1'b0;
    logic [CNT_W-1:0] t_count = '0;
    logic [CNT_W-1:0] t_psc_written = '0;
    logic [CNT_W-1:0] t_psc_active = '0;
    logic [CNT_W-1:0] t_psc_count = '0;
    logic [CNT_W-1:0] t_reload = '1;

    bus_request_t bus_requests[$];
    result_t      due_responses[$];
    bus_request_t next_request;
    result_t      want;

    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_ticks = 0;
    int unsigned n_updates = 0;
    int unsigned n_irq_high = 0;
    int unsigned send_gap;
    int unsigned sink_gap;
    int unsigned rsp_hold_left;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        // every so often a stretch where neither side idles
        if (cycle_count[10:9] == 2'b11)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic void restart_counts();
        t_count = '0;
        t_psc_count = '0;
        t_psc_active = t_psc_written;
    endfunction

    function automatic result_t predict_timer_response(input item_t it);
        result_t r;
        r.read_data = '0;
        case (it.cmd)
            CMD_TICK:
            begin
                if (t_en)
                begin
                    if (t_psc_count != t_psc_active)
                        t_psc_count = t_psc_count + 1'b1;
                    else
                    begin
                        t_psc_count = '0;
                        if (t_count == t_reload)
                        begin
                            restart_counts();
                            t_flag = 1'b1;
                            n_updates++;
                            if (t_opm)
                                t_en = 1'b0;
                        end
                        else
                            t_count = t_count + 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                case (it.reg_index)
                    REG_CTRL:
                    begin
                        r.read_data[CTRL_EN_BIT] = t_en;
                        r.read_data[CTRL_URS_BIT] = t_urs;
                        r.read_data[CTRL_OPM_BIT] = t_opm;
                    end
                    REG_IRQ_EN:  r.read_data[0] = t_irq_en;
                    REG_STATUS:  r.read_data[0] = t_flag;
                    REG_COUNTER: r.read_data = t_count;
                    REG_PRESC:   r.read_data = t_psc_written;
                    REG_RELOAD:  r.read_data = t_reload;
                    default:     r.read_data = '0;
                endcase
            end
            CMD_WRITE:
            begin
                case (it.reg_index)
                    REG_CTRL:
                    begin
                        t_en = it.write_data[CTRL_EN_BIT];
                        t_urs = it.write_data[CTRL_URS_BIT];
                        t_opm = it.write_data[CTRL_OPM_BIT];
                    end
                    REG_IRQ_EN: t_irq_en = it.write_data[0];
                    REG_STATUS:
                    begin
                        // writing one leaves the flag alone
                        if (!it.write_data[0])
                            t_flag = 1'b0;
                    end
                    REG_EVENT:
                    begin
                        if (it.write_data[0])
                        begin
                            restart_counts();
                            if (!t_urs)
                                t_flag = 1'b1;
                        end
                    end
                    REG_COUNTER: t_count = it.write_data;
                    REG_PRESC:   t_psc_written = it.write_data;
                    REG_RELOAD:  t_reload = it.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.irq = t_flag & t_irq_en;
        return r;
    endfunction

    task automatic push_req(input logic [1:0] c, input logic [2:0] ri, input logic [15:0] wd,
                            input bit drain);
        bus_request_t b;
        b.item.cmd = c;
        b.item.reg_index = ri;
        b.item.write_data = wd;
        b.drain = drain;
        bus_requests.push_back(b);
    endtask

    task automatic push_noise();
        push_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 16'($urandom), 1'b0);
    endtask

    // program a short period, start the timer and let it run with bus traffic mixed in
    task automatic add_timer_run(input bit drain);
        logic [15:0] d;
        int unsigned rl;
        int unsigned r;
        rl = $urandom_range(0, 12);
        d = 16'($urandom_range(0, 3));
        push_req(CMD_WRITE, REG_PRESC, d, drain);
        d = 16'(rl);
        push_req(CMD_WRITE, REG_RELOAD, d, 1'b0);
        if ($urandom_range(0, 9) == 0)
            d = 16'($urandom_range(16'hfffd, 16'hffff));
        else
            d = 16'($urandom_range(0, rl));
        push_req(CMD_WRITE, REG_COUNTER, d, 1'b0);
        push_req(CMD_WRITE, REG_IRQ_EN, 16'($urandom), 1'b0);
        d = 16'($urandom);
        d[CTRL_EN_BIT] = 1'b0;
        push_req(CMD_WRITE, REG_CTRL, d, 1'b0);
        d = 16'($urandom);
        d[0] = 1'b1;
        push_req(CMD_WRITE, REG_EVENT, d, 1'b0);
        if ($urandom_range(0, 1) == 1)
        begin
            d = 16'($urandom);
            d[0] = 1'b0;
            push_req(CMD_WRITE, REG_STATUS, d, 1'b0);
        end
        d = 16'($urandom);
        d[CTRL_EN_BIT] = 1'b1;
        push_req(CMD_WRITE, REG_CTRL, d, 1'b0);
        repeat ($urandom_range(5, 40))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                push_req(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom), 1'b0);
            else if (r < 85)
                push_req(CMD_READ, 3'($urandom_range(0, 7)), 16'($urandom), 1'b0);
            else if (r < 90)
                push_req(CMD_WRITE, REG_STATUS, 16'($urandom), 1'b0);
            else if (r < 93)
                push_req(CMD_WRITE, REG_EVENT, 16'($urandom), 1'b0);
            else if (r < 96)
                push_req(CMD_WRITE, REG_CTRL, 16'($urandom), 1'b0);
            else
                push_noise();
        end
    endtask

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // long response hold-off so the output buffer fills and req.ready drops
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_hold_left <= 0;
        else if (rsp_hold_left != 0)
            rsp_hold_left <= rsp_hold_left - 1;
        else if (cycle_count == HOLD_AT_A || cycle_count == HOLD_AT_B)
            rsp_hold_left <= HOLD_CYCLES;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.cmd <= CMD_TICK;
            req.reg_index <= REG_CTRL;
            req.write_data <= '0;
            send_gap <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (send_gap != 0 && rsp_hold_left == 0)
            begin
                req.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (bus_requests.size() != 0 && (!bus_requests[0].drain ||
                     (!(req.valid && req.ready) && due_responses.size() == 0)))
            begin
                next_request = bus_requests.pop_front();
                req.valid <= 1'b1;
                req.cmd <= next_request.item.cmd;
                req.reg_index <= next_request.item.reg_index;
                req.write_data <= next_request.item.write_data;
                send_gap <= pick_gap();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // response sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            sink_gap <= 0;
        end
        else if (rsp_hold_left != 0)
            rsp.ready <= 1'b0;
        else if (sink_gap != 0)
        begin
            rsp.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
                sink_gap <= pick_gap();
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $display("%0t: response with none expected, read_data %h irq %b",
                             $time, rsp.read_data, rsp.irq);
                    errors++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                        errors++;
                    end
                    if (rsp.irq !== want.irq)
                    begin
                        $display("%0t: irq expected %b actual %b", $time, want.irq, rsp.irq);
                        errors++;
                    end
                    if (rsp.irq === 1'b1)
                        n_irq_high++;
                end
            end
            if (req.valid && req.ready)
            begin
                due_responses.push_back(predict_timer_response('{req.cmd, req.reg_index,
                                                                 req.write_data}));
                n_sent++;
                if (req.cmd == CMD_TICK)
                    n_ticks++;
            end
        end
    end

    initial
    begin
        int unsigned run_idx;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_TICK;
        req.reg_index = REG_CTRL;
        req.write_data = '0;
        rsp.ready = 1'b0;

        // directed: reset values, unused codes, register extremes
        push_req(CMD_READ, REG_RELOAD, 16'h0000, 1'b0);
        push_req(CMD_READ, 3'd7, 16'hffff, 1'b0);
        push_req(CMD_WRITE, 3'd7, 16'hffff, 1'b0);
        push_req(CMD_WRITE, REG_CTRL, 16'hffff, 1'b0);
        push_req(CMD_READ, REG_CTRL, 16'h0000, 1'b0);
        push_req(CMD_WRITE, REG_CTRL, 16'h0000, 1'b0);
        push_req(CMD_WRITE, REG_PRESC, 16'hffff, 1'b0);
        push_req(CMD_READ, REG_PRESC, 16'h0000, 1'b0);
        push_req(CMD_WRITE, REG_PRESC, 16'h0000, 1'b0);
        // software update with update source 0 sets the flag
        push_req(CMD_WRITE, REG_EVENT, 16'h0001, 1'b0);
        push_req(CMD_WRITE, REG_IRQ_EN, 16'hffff, 1'b0);
        push_req(CMD_WRITE, REG_STATUS, 16'hffff, 1'b0);
        push_req(CMD_WRITE, REG_STATUS, 16'hfffe, 1'b0);
        push_req(CMD_WRITE, REG_RELOAD, 16'h0001, 1'b0);
        push_req(CMD_WRITE, REG_CTRL, 16'h0001, 1'b0);
        repeat (3)
            push_req(CMD_TICK, 3'd0, 16'h0000, 1'b0);
        // counter above reload wraps through all ones with no update
        push_req(CMD_WRITE, REG_COUNTER, 16'hffff, 1'b0);
        push_req(CMD_TICK, 3'd7, 16'hffff, 1'b0);
        push_req(CMD_READ, REG_COUNTER, 16'h0000, 1'b0);
        push_req(2'd3, 3'd7, 16'hffff, 1'b0);
        push_req(CMD_WRITE, REG_STATUS, 16'h0000, 1'b0);
        // one-pulse with update source 1: event does not flag, wrap stops the timer
        push_req(CMD_WRITE, REG_CTRL, 16'h000d, 1'b0);
        push_req(CMD_WRITE, REG_EVENT, 16'hffff, 1'b0);
        repeat (2)
            push_req(CMD_TICK, 3'd0, 16'h0000, 1'b0);
        push_req(CMD_READ, REG_CTRL, 16'h0000, 1'b0);
        push_req(CMD_TICK, 3'd0, 16'h0000, 1'b0);
        push_req(CMD_READ, REG_STATUS, 16'h0000, 1'b0);
        push_req(CMD_WRITE, REG_EVENT, 16'hfffe, 1'b0);

        // random: mostly programmed timer runs, noise in between
        run_idx = 0;
        while (bus_requests.size() < RANDOM_ITEMS + 30)
        begin
            add_timer_run(run_idx == 0 || $urandom_range(0, 7) == 0);
            repeat ($urandom_range(0, 3))
                push_noise();
            run_idx++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (bus_requests.size() != 0 || req.valid)
            @(posedge clk);
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d transactions in %0d timer runs: %0d ticks, %0d counter updates",
                 n_sent, run_idx, n_ticks, n_updates);
        $display("%0d responses carried irq high, %0d mismatches", n_irq_high, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/prt_pkg.sv
hw/rtl/prt_if.sv
hw/rtl/prt_regs.sv
hw/rtl/prescaled_reload_timer.sv
dv/tb_prescaled_reload_timer.sv
